FILE: rtl/core/kms_pkg.sv
// Shared constants, types and score codes for the keyword match scorer.
package kms_pkg;

    localparam int MAX_KEY    = 16;
    localparam int POS_BITS   = 16;
    localparam int HIST_DEPTH = MAX_KEY + 1;
    localparam int LEN_W      = $clog2(MAX_KEY + 1);
    localparam int KEY_BYTES  = 16;
    localparam int KEY_W      = 8 * KEY_BYTES;
    localparam int KLEN_W     = 5;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;

    localparam longint unsigned POS_MAX  = (64'd1 << POS_BITS) - 64'd1;
    localparam longint unsigned SEEN_CAP = POS_MAX + MAX_KEY + 2;
    localparam int SEEN_W = $clog2(SEEN_CAP + 1);

    localparam int SCORE_W     = 4;
    localparam int IDX_W       = 17;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 24;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    localparam logic [SCORE_W-1:0] SCORE_NONE  = 4'd0;
    localparam logic [SCORE_W-1:0] SCORE_PART  = 4'd6;
    localparam logic [SCORE_W-1:0] SCORE_WHOLE = 4'd8;
    localparam logic [SCORE_W-1:0] SCORE_EXACT = 4'd10;

    typedef logic [7:0] byte_t;
    typedef byte_t [HIST_DEPTH-1:0] hist_t;

    // Two judged candidates of one text byte, handed from front to back.
    typedef struct packed {
        logic [SCORE_W-1:0]  score_a;
        logic [POS_BITS-1:0] pos_a;
        logic [SCORE_W-1:0]  score_b;
        logic [POS_BITS-1:0] pos_b;
        logic                last;
    } cand_t;

endpackage

FILE: rtl/core/keyword_match_scorer.sv
// Top level of the keyword match scorer: configuration registers and front/queue/back.
// Takes text bytes and searches them, ignoring ASCII case, for a keyword of 1 to 16 bytes.
// On the byte marked tlast one result passes through the queue and the output register to
// the m_ side: score 0 (none), 6 (inside a word), 8 (whole word) or 10 (whole word, exact
// case, which stops the search), and the start index of the earliest best match, or -1.
// The rate is one byte per cycle while the queue has room, set by the front end, which
// compares the whole keyword against its byte window combinationally; a two-entry queue
// lets the front keep accepting while a result waits in the output register. Configuration
// writes are taken at any time but must only be made while no text is in flight.
module keyword_match_scorer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kms_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] text_byte
    input  logic                             s_tlast,   // last_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [kms_pkg::OUT_DATA_W-1:0]   m_tdata,   // [3:0] score, [20:4] match_index
    input  logic                             cfg_wr_en,
    input  logic [kms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kms_pkg::CFG_W-1:0]        cfg_wdata
);

    logic [kms_pkg::CFG_W-1:0]  key_low_reg, key_low_next;
    logic [kms_pkg::CFG_W-1:0]  key_high_reg, key_high_next;
    logic [kms_pkg::KLEN_W-1:0] key_len_reg, key_len_next;

    logic           q_push, q_full, q_valid, q_pop;
    kms_pkg::cand_t q_in, q_out;

    always_comb begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        key_len_next  = key_len_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                kms_pkg::CFG_KEY_LOW:  key_low_next  = cfg_wdata;
                kms_pkg::CFG_KEY_HIGH: key_high_next = cfg_wdata;
                kms_pkg::CFG_KEY_LEN:  key_len_next  = cfg_wdata[kms_pkg::KLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= kms_pkg::KLEN_W'(1);
        end else begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
            key_len_reg  <= key_len_next;
        end
    end

    kms_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .key_chars  ({key_high_reg, key_low_reg}),
        .key_length (key_len_reg),
        .q_push     (q_push),
        .q_data     (q_in),
        .q_full     (q_full)
    );

    kms_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .valid     (q_valid),
        .data      (q_out),
        .pop       (q_pop)
    );

    kms_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/core/kms_front.sv
// Front end: byte window, position count and parallel keyword judging.
module kms_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kms_pkg::IN_DATA_W-1:0] s_tdata,   // [7:0] text_byte
    input  logic                          s_tlast,
    input  logic [kms_pkg::KEY_W-1:0]     key_chars,
    input  logic [kms_pkg::KLEN_W-1:0]    key_length,
    output logic                          q_push,
    output kms_pkg::cand_t                q_data,
    input  logic                          q_full
);

    kms_pkg::hist_t                 hist_reg, hist_next;
    logic [kms_pkg::SEEN_W-1:0]     seen_reg, seen_next;
    kms_pkg::hist_t                 win_b;
    logic [kms_pkg::LEN_W-1:0]      n;
    logic [kms_pkg::SEEN_W:0]       pw, p1, nw, sa, sb;
    logic                           ok_a, ok_b;
    logic [kms_pkg::SCORE_W-1:0]    judge_a, judge_b;
    kms_pkg::byte_t                 cur;

    function automatic kms_pkg::byte_t fold(input kms_pkg::byte_t c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_alnum(input kms_pkg::byte_t c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // Match of n bytes ending at win[0]; left neighbor is win[n].
    function automatic logic [kms_pkg::SCORE_W-1:0] judge(
        input kms_pkg::hist_t              win,
        input logic [kms_pkg::LEN_W-1:0]   len,
        input logic [kms_pkg::KEY_W-1:0]   key,
        input logic                        left_edge,
        input logic                        right_edge,
        input kms_pkg::byte_t              right_byte
    );
        logic                         hit;
        logic                         exact;
        kms_pkg::byte_t               t;
        kms_pkg::byte_t               k;
        logic [kms_pkg::LEN_W-1:0]    idx;
        logic [kms_pkg::SCORE_W-1:0]  sc;
        hit   = 1'b1;
        exact = 1'b1;
        for (int j = 0; j < kms_pkg::MAX_KEY; j++) begin
            if (j < len) begin
                idx = len - kms_pkg::LEN_W'(j + 1);
                t   = win[idx];
                k   = key[8*j +: 8];
                if (fold(t) != fold(k)) hit = 1'b0;
                if (t != k) exact = 1'b0;
            end
        end
        if (!hit) begin
            sc = kms_pkg::SCORE_NONE;
        end else if (!left_edge && is_alnum(win[len])) begin
            sc = kms_pkg::SCORE_PART;
        end else if (!right_edge && is_alnum(right_byte)) begin
            sc = kms_pkg::SCORE_PART;
        end else begin
            sc = exact ? kms_pkg::SCORE_EXACT : kms_pkg::SCORE_WHOLE;
        end
        return sc;
    endfunction

    function automatic logic [kms_pkg::POS_BITS-1:0] clamp(input logic [kms_pkg::SEEN_W:0] s);
        if (s > (kms_pkg::SEEN_W + 1)'(kms_pkg::POS_MAX)) return '1;
        return s[kms_pkg::POS_BITS-1:0];
    endfunction

    assign cur      = s_tdata[7:0];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        if (key_length == '0) begin
            n = kms_pkg::LEN_W'(1);
        end else if (key_length > kms_pkg::KLEN_W'(kms_pkg::MAX_KEY)) begin
            n = kms_pkg::LEN_W'(kms_pkg::MAX_KEY);
        end else begin
            n = kms_pkg::LEN_W'(key_length);
        end
    end

    always_comb begin
        win_b[0] = cur;
        for (int k = 1; k < kms_pkg::HIST_DEPTH; k++) begin
            win_b[k] = hist_reg[k-1];
        end
    end

    // a: match ending on the previous byte; b: match ending on this byte (last only)
    assign pw   = {1'b0, seen_reg};
    assign p1   = pw + 1'b1;
    assign nw   = (kms_pkg::SEEN_W + 1)'(n);
    assign ok_a = pw >= nw;
    assign ok_b = s_tlast && (p1 >= nw);
    assign sa   = pw - nw;
    assign sb   = p1 - nw;

    assign judge_a = judge(hist_reg, n, key_chars, pw == nw, 1'b0, cur);
    assign judge_b = judge(win_b, n, key_chars, p1 == nw, 1'b1, cur);

    always_comb begin
        q_data.score_a = ok_a ? judge_a : kms_pkg::SCORE_NONE;
        q_data.pos_a   = clamp(sa);
        q_data.score_b = ok_b ? judge_b : kms_pkg::SCORE_NONE;
        q_data.pos_b   = clamp(sb);
        q_data.last    = s_tlast;
    end

    always_comb begin
        hist_next = hist_reg;
        seen_next = seen_reg;
        if (q_push) begin
            hist_next = win_b[kms_pkg::HIST_DEPTH-1:0];
            if (s_tlast) begin
                seen_next = '0;
            end else if (seen_reg < kms_pkg::SEEN_W'(kms_pkg::SEEN_CAP)) begin
                seen_next = seen_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hist_reg <= hist_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else begin
            seen_reg <= seen_next;
        end
    end

endmodule

FILE: rtl/core/kms_queue.sv
// Short queue of judged candidates between front and back.
module kms_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  kms_pkg::cand_t push_data,
    output logic           full,
    output logic           valid,
    output kms_pkg::cand_t data,
    input  logic           pop
);

    kms_pkg::cand_t               mem_reg [kms_pkg::QUEUE_DEPTH];
    logic [kms_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [kms_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [kms_pkg::QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [kms_pkg::QPTR_W-1:0] ptr_inc(input logic [kms_pkg::QPTR_W-1:0] p);
        if (p == kms_pkg::QPTR_W'(kms_pkg::QUEUE_DEPTH - 1)) return '0;
        return p + 1'b1;
    endfunction

    assign full  = count_reg == kms_pkg::QCNT_W'(kms_pkg::QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/kms_back.sv
// Back end: best-score tracking and the result output register.
module kms_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  kms_pkg::cand_t                 q_data,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [kms_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int PAD_W = kms_pkg::OUT_DATA_W - kms_pkg::IDX_W - kms_pkg::SCORE_W;

    logic [kms_pkg::SCORE_W-1:0]  best_score_reg, best_score_next;
    logic [kms_pkg::POS_BITS-1:0] best_pos_reg, best_pos_next;
    logic                         exact_reg, exact_next;
    logic                         out_valid_reg, out_valid_next;
    logic [kms_pkg::SCORE_W-1:0]  out_score_reg, out_score_next;
    logic [kms_pkg::IDX_W-1:0]    out_idx_reg, out_idx_next;

    logic [kms_pkg::SCORE_W-1:0]  sc_a, sc_b;
    logic [kms_pkg::POS_BITS-1:0] ps_a, ps_b;
    logic                         ex_a, ex_b;
    logic                         out_free;

    function automatic logic [kms_pkg::IDX_W-1:0] to_index(input logic [kms_pkg::POS_BITS-1:0] p);
        logic [kms_pkg::POS_BITS+kms_pkg::IDX_W-1:0] wide;
        wide = {{kms_pkg::IDX_W{1'b0}}, p};
        return wide[kms_pkg::IDX_W-1:0];
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = q_valid && (!q_data.last || out_free);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_idx_reg, out_score_reg};

    // Candidate a is recorded before candidate b; an exact hit freezes the result.
    always_comb begin
        sc_a = best_score_reg;
        ps_a = best_pos_reg;
        ex_a = exact_reg;
        if (!exact_reg) begin
            if (q_data.score_a == kms_pkg::SCORE_EXACT) begin
                sc_a = kms_pkg::SCORE_EXACT;
                ps_a = q_data.pos_a;
                ex_a = 1'b1;
            end else if (q_data.score_a > best_score_reg) begin
                sc_a = q_data.score_a;
                ps_a = q_data.pos_a;
            end
        end
        sc_b = sc_a;
        ps_b = ps_a;
        ex_b = ex_a;
        if (!ex_a) begin
            if (q_data.score_b == kms_pkg::SCORE_EXACT) begin
                sc_b = kms_pkg::SCORE_EXACT;
                ps_b = q_data.pos_b;
                ex_b = 1'b1;
            end else if (q_data.score_b > sc_a) begin
                sc_b = q_data.score_b;
                ps_b = q_data.pos_b;
            end
        end
    end

    always_comb begin
        best_score_next = best_score_reg;
        best_pos_next   = best_pos_reg;
        exact_next      = exact_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_score_next  = out_score_reg;
        out_idx_next    = out_idx_reg;
        if (q_pop) begin
            if (q_data.last) begin
                best_score_next = kms_pkg::SCORE_NONE;
                exact_next      = 1'b0;
                out_valid_next  = 1'b1;
                out_score_next  = sc_b;
                out_idx_next    = (sc_b == kms_pkg::SCORE_NONE) ? '1 : to_index(ps_b);
            end else begin
                best_score_next = sc_b;
                best_pos_next   = ps_b;
                exact_next      = ex_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        best_pos_reg  <= best_pos_next;
        out_score_reg <= out_score_next;
        out_idx_reg   <= out_idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_score_reg <= kms_pkg::SCORE_NONE;
            exact_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            best_score_reg <= best_score_next;
            exact_reg      <= exact_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    a_exact_is_top: assert property (@(posedge aclk) disable iff (!aresetn)
        exact_reg |-> best_score_reg == kms_pkg::SCORE_EXACT)
        else $error("exact flag set without top score");

    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_data.last |=> !exact_reg && best_score_reg == kms_pkg::SCORE_NONE
                                 && m_tvalid)
        else $error("state not cleared or no result after last byte");

    a_score_code: assert property (@(posedge aclk) disable iff (!aresetn)
        best_score_reg == kms_pkg::SCORE_NONE || best_score_reg == kms_pkg::SCORE_PART ||
        best_score_reg == kms_pkg::SCORE_WHOLE || best_score_reg == kms_pkg::SCORE_EXACT)
        else $error("best score holds an illegal value");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !(q_pop && q_data.last))
        else $error("pending result overwritten");

endmodule

FILE: bench/score_checker.sv
// Checker for the keyword match scorer: predicts each result from the stream and compares.
`timescale 1ns / 100ps
module score_checker
    import kms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,    // [7:0] text_byte
    input  logic                  s_tlast,    // last_byte
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,    // [3:0] score, [20:4] match_index
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output int                    fail_count,
    output int                    results_seen,
    output int                    exact_hits
);

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [IDX_W-1:0]   index;
    } score_rec_t;

    score_rec_t expected_scores[$];
    score_rec_t want;

    logic [63:0]       key_lo;
    logic [63:0]       key_hi;
    logic [KLEN_W-1:0] key_len;

    byte_t              recent [HIST_DEPTH];
    byte_t              win [HIST_DEPTH+1];
    int                 seen;
    logic [SCORE_W-1:0] best;
    int                 best_pos;
    bit                 exact_done;

    logic [SCORE_W-1:0] got_score;
    logic [IDX_W-1:0]   got_index;
    int n_fail = 0;
    int n_results = 0;
    int n_exact = 0;

    function automatic byte_t fold_case(byte_t c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit is_word_char(byte_t c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic byte_t key_byte(int j);
        logic [127:0] k;
        k = {key_hi, key_lo};
        return k[8*j +: 8];
    endfunction

    function automatic int word_len();
        if (key_len == 0) return 1;
        if (key_len > MAX_KEY) return MAX_KEY;
        return int'(key_len);
    endfunction

    // win[0] is the newest byte; keyword byte j sits at win[first - j]
    function automatic logic [SCORE_W-1:0] match_score(int first, int n, bit left_edge,
                                                       bit right_edge);
        bit    exact;
        byte_t t;
        byte_t k;
        exact = 1'b1;
        for (int j = 0; j < n; j++) begin
            t = win[first - j];
            k = key_byte(j);
            if (fold_case(t) != fold_case(k)) return SCORE_NONE;
            if (t != k) exact = 1'b0;
        end
        if (!left_edge && is_word_char(win[first + 1])) return SCORE_PART;
        if (!right_edge && is_word_char(win[first - n])) return SCORE_PART;
        return exact ? SCORE_EXACT : SCORE_WHOLE;
    endfunction

    function automatic void keep_best(logic [SCORE_W-1:0] sc, int start);
        int pos;
        pos = (start > POS_MAX) ? int'(POS_MAX) : start;
        if (sc == SCORE_EXACT) begin
            best       = sc;
            best_pos   = pos;
            exact_done = 1'b1;
        end else if (sc > best) begin
            best     = sc;
            best_pos = pos;
        end
    endfunction

    function automatic void clear_text();
        for (int k = 0; k < HIST_DEPTH; k++) recent[k] = 8'h00;
        seen       = 0;
        best       = SCORE_NONE;
        best_pos   = -1;
        exact_done = 1'b0;
    endfunction

    function automatic void scan_text_byte(byte_t cur, logic last);
        int n;
        int s;
        n = word_len();
        win[0] = cur;
        for (int k = 0; k < HIST_DEPTH; k++) win[k + 1] = recent[k];
        // match ending on the previous byte, current byte as right neighbor
        if (!exact_done && seen >= n) begin
            s = seen - n;
            keep_best(match_score(n, n, s == 0, 1'b0), s);
        end
        // match ending on the last byte, text edge on the right
        if (!exact_done && last && seen + 1 >= n) begin
            s = seen + 1 - n;
            keep_best(match_score(n - 1, n, s == 0, 1'b1), s);
        end
        if (last) begin
            expected_scores.push_back('{score: best, index: best_pos[IDX_W-1:0]});
            clear_text();
        end else begin
            for (int k = HIST_DEPTH - 1; k > 0; k--) recent[k] = recent[k - 1];
            recent[0] = cur;
            if (seen < SEEN_CAP) seen++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            key_lo  = '0;
            key_hi  = '0;
            key_len = KLEN_W'(1);
            expected_scores.delete();
            clear_text();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_KEY_LOW:  key_lo  = cfg_wdata;
                    CFG_KEY_HIGH: key_hi  = cfg_wdata;
                    CFG_KEY_LEN:  key_len = cfg_wdata[KLEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) scan_text_byte(s_tdata[7:0], s_tlast);
            if (m_tvalid && m_tready) begin
                n_results++;
                got_score = m_tdata[SCORE_W-1:0];
                got_index = m_tdata[SCORE_W +: IDX_W];
                if (expected_scores.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected result, expected none, actual score %0d index %0d",
                             $time, got_score, $signed(got_index));
                end else begin
                    want = expected_scores.pop_front();
                    if (got_score != want.score) begin
                        n_fail++;
                        $display("%0t: score mismatch, expected %0d, actual %0d",
                                 $time, want.score, got_score);
                    end
                    if (got_index != want.index) begin
                        n_fail++;
                        $display("%0t: match_index mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.index), $signed(got_index));
                    end
                    if (m_tdata[OUT_DATA_W-1:SCORE_W+IDX_W] != '0) begin
                        n_fail++;
                        $display("%0t: tdata pad mismatch, expected 0, actual %0h",
                                 $time, m_tdata[OUT_DATA_W-1:SCORE_W+IDX_W]);
                    end
                    if (want.score == SCORE_EXACT) n_exact++;
                end
            end
        end
        fail_count   <= n_fail;
        results_seen <= n_results;
        exact_hits   <= n_exact;
    end

endmodule

FILE: bench/testbench.sv
// Top of the keyword match scorer bench: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 100ps
module testbench;
    import kms_pkg::*;

    typedef enum int {CH_LETTER, CH_DIGIT, CH_MARK, CH_HIGH, CH_ANY} char_kind_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_KEY_LOW;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    int fail_count;
    int results_seen;
    int exact_hits;

    bit           tx_gaps      = 1'b1;
    bit           rx_gaps      = 1'b1;
    int           rx_hold      = 0;
    int           texts_sent   = 0;
    int           bytes_sent   = 0;
    int           random_bytes = 0;
    int           key_loads    = 0;
    logic [127:0] key_img      = '0;
    int           key_span     = 1;

    keyword_match_scorer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    score_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .results_seen (results_seen),
        .exact_hits   (exact_hits)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("%0t: run timed out", $time);
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stall per request, or a long hold when asked
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = rx_gaps ? $urandom_range(0, 8) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    function automatic byte_t rand_char(char_kind_t kind);
        byte_t c;
        string marks;
        marks = " .,-/:@[`{";
        case (kind)
            CH_LETTER: begin
                c = 8'($urandom_range(0, 25)) + "a";
                if ($urandom_range(0, 1)) c = c - 8'd32;
            end
            CH_DIGIT: c = 8'($urandom_range(0, 9)) + "0";
            CH_MARK:  c = marks[$urandom_range(0, marks.len() - 1)];
            CH_HIGH:  c = 8'($urandom_range(128, 255));
            default:  c = 8'($urandom_range(1, 255));
        endcase
        return c;
    endfunction

    task automatic send_byte(input byte_t b, input logic last);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (last) texts_sent++;
    endtask

    task automatic send_text(input byte_t txt[$]);
        for (int i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
    endtask

    // block idle: every text answered, then the pipeline left to drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_seen < texts_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_key(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [KLEN_W-1:0] len);
        logic [63:0] lw;
        lw        = {$urandom, $urandom};
        lw[4:0]   = len;
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_KEY_LOW;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= CFG_KEY_HIGH;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_index <= CFG_KEY_LEN;
        cfg_wdata <= lw;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        key_img  = {hi, lo};
        key_span = (len == 0) ? 1 : (len > MAX_KEY) ? MAX_KEY : int'(len);
        key_loads++;
    endtask

    task automatic random_key();
        logic [127:0]      img;
        logic [KLEN_W-1:0] code;
        int                span;
        int                r;
        img = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       code = KLEN_W'(16);
            1:       code = KLEN_W'($urandom_range(6, 15));
            2:       code = $urandom_range(0, 1) ? KLEN_W'(0) : KLEN_W'($urandom_range(17, 31));
            default: code = KLEN_W'($urandom_range(1, 5));
        endcase
        span = (code == 0) ? 1 : (code > MAX_KEY) ? MAX_KEY : int'(code);
        for (int j = 0; j < span; j++) begin
            r = $urandom_range(0, 9);
            img[8*j +: 8] = rand_char(r < 6 ? CH_LETTER : r == 6 ? CH_DIGIT :
                                      r == 7 ? CH_MARK : r == 8 ? CH_HIGH : CH_ANY);
        end
        load_key(img[63:0], img[127:64], code);
    endtask

    // mostly keyword copies with random case and neighbors; some pure noise
    task automatic make_text(output byte_t txt[$]);
        byte_t c;
        bit    flip;
        int    cut;
        txt = {};
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 24)) txt.push_back(rand_char(CH_ANY));
            return;
        end
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 7))
                0, 1, 2: begin
                    flip = $urandom_range(0, 1);
                    for (int j = 0; j < key_span; j++) begin
                        c = key_img[8*j +: 8];
                        if (flip && (c | 8'h20) >= "a" && (c | 8'h20) <= "z" &&
                            $urandom_range(0, 1))
                            c = c ^ 8'h20;
                        txt.push_back(c);
                    end
                end
                3: begin
                    cut = $urandom_range(1, key_span);
                    for (int j = 0; j < cut; j++) txt.push_back(key_img[8*j +: 8]);
                end
                4: txt.push_back(rand_char(CH_MARK));
                5: txt.push_back(rand_char($urandom_range(0, 1) ? CH_LETTER : CH_DIGIT));
                6: txt.push_back(rand_char($urandom_range(0, 1) ? CH_HIGH : CH_ANY));
                default: txt.push_back(key_img[8*$urandom_range(0, key_span - 1) +: 8]);
            endcase
        end
    endtask

    initial begin
        byte_t txt[$];
        bit    pressured;
        pressured = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset keyword is a single zero byte
        txt = {"a"};
        send_text(txt);
        txt = {"q", 8'h00, "r"};
        send_text(txt);
        settle();

        load_key({{6{8'h5A}}, "b", "A"}, 64'hFFFF_FFFF_FFFF_FFFF, KLEN_W'(2));
        txt = {"A", "b"};
        send_text(txt);
        txt = {"a", "B", "-", "A", "b"};
        send_text(txt);
        settle();

        // length code 0 acts as one byte; high bytes are never folded
        load_key(64'h0000_0000_0000_00E9, 64'h0, KLEN_W'(0));
        txt = {8'hC9, 8'hE9};
        send_text(txt);
        settle();

        load_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, KLEN_W'(31));
        txt = {};
        repeat (16) txt.push_back(8'hFF);
        send_text(txt);
        settle();

        while (random_bytes < 700) begin
            random_key();
            tx_gaps = $urandom_range(0, 3) != 0;
            rx_gaps = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(3, 10)) begin
                make_text(txt);
                send_text(txt);
                random_bytes += txt.size();
            end
            settle();
            if (!pressured && random_bytes > 300) begin
                // output held off while short texts keep coming, so the input stalls
                pressured = 1'b1;
                tx_gaps   = 1'b0;
                rx_hold   = 100;
                repeat (24) begin
                    txt = {};
                    repeat ($urandom_range(1, 3)) txt.push_back(rand_char(CH_ANY));
                    send_text(txt);
                    random_bytes += txt.size();
                end
                settle();
            end
        end

        repeat (8) @(posedge aclk);
        $display("Ran %0d texts, %0d bytes, %0d keyword settings; %0d results checked, %0d exact.",
                 texts_sent, bytes_sent, key_loads, results_seen, exact_hits);
        $display("Included length codes 0 and 31, a zero text byte and a long output hold.");
        if (fail_count == 0 && results_seen == texts_sent) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
